// ===== rtl/core/lsc_pkg.sv =====
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int InW  = 24;
  localparam int OutW = 32;
  localparam int ThrW = 63;
  // 2x2 minor: two 24x24 products, difference -> 49 bits signed
  localparam int MinW = 2 * InW + 1;
  // 3x3 determinant: three 24x49 products summed -> 75 bits signed
  localparam int DetW = 3 * InW + 3;
  localparam int MagW = DetW - 1;

  typedef struct packed {
    logic signed [InW-1:0] col0_row0;
    logic signed [InW-1:0] col0_row1;
    logic signed [InW-1:0] col0_row2;
    logic signed [InW-1:0] col1_row0;
    logic signed [InW-1:0] col1_row1;
    logic signed [InW-1:0] col1_row2;
    logic signed [InW-1:0] col2_row0;
    logic signed [InW-1:0] col2_row1;
    logic signed [InW-1:0] col2_row2;
    logic signed [InW-1:0] rhs_row0;
    logic signed [InW-1:0] rhs_row1;
    logic signed [InW-1:0] rhs_row2;
  } lsc_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] solution_first;
    logic signed [OutW-1:0] solution_second;
    logic signed [OutW-1:0] solution_third;
    logic                   singular;
  } lsc_out_t;

endpackage

// ===== rtl/core/lsc_det.sv =====
`timescale 1ns / 1ps
// Four 3x3 determinants (A and three Cramer numerators) in four stages:
// products, minors, cofactor products, sum.
module lsc_det (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  lsc_pkg::lsc_in_t      in_word,
  output logic                  out_vld,
  output logic signed [lsc_pkg::DetW-1:0] out_det [4]
);
  import lsc_pkg::*;

  // column sets: det A = (c0,c1,c2); n0 = (r,c1,c2); n1 = (c0,r,c2); n2 = (c0,c1,r)
  logic signed [InW-1:0] c [4][3];
  always_comb begin
    c[0][0] = in_word.col0_row0; c[0][1] = in_word.col0_row1; c[0][2] = in_word.col0_row2;
    c[1][0] = in_word.col1_row0; c[1][1] = in_word.col1_row1; c[1][2] = in_word.col1_row2;
    c[2][0] = in_word.col2_row0; c[2][1] = in_word.col2_row1; c[2][2] = in_word.col2_row2;
    c[3][0] = in_word.rhs_row0;  c[3][1] = in_word.rhs_row1;  c[3][2] = in_word.rhs_row2;
  end

  localparam int PW = 2 * InW;
  // minors needed: (1,2) (3,2) (1,3); each six products
  logic signed [PW-1:0]   pr_r [3][6];
  logic signed [InW-1:0]  p_r  [4][3];
  logic                   v1_r, v2_r, v3_r, v4_r;
  logic signed [MinW-1:0] m_r  [3][3];
  logic signed [InW-1:0]  p2_r [4][3];
  logic signed [DetW-1:0] t_r  [4][3];
  logic signed [DetW-1:0] det_r [4];

  function automatic logic [3:0] qt(input int k);
    // columns q,t for minor k
    unique case (k)
      0:       qt = {2'd1, 2'd2};
      1:       qt = {2'd3, 2'd2};
      default: qt = {2'd1, 2'd3};
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic [1:0] q, t;
      {q, t} = qt(k);
      pr_r[k][0] <= c[q][1] * c[t][2];
      pr_r[k][1] <= c[q][2] * c[t][1];
      pr_r[k][2] <= c[q][0] * c[t][2];
      pr_r[k][3] <= c[q][2] * c[t][0];
      pr_r[k][4] <= c[q][0] * c[t][1];
      pr_r[k][5] <= c[q][1] * c[t][0];
    end
    p_r[0] <= c[0]; p_r[1] <= c[3]; p_r[2] <= c[0]; p_r[3] <= c[0];
    for (int k = 0; k < 3; k++) begin
      m_r[k][0] <= MinW'(pr_r[k][0]) - MinW'(pr_r[k][1]);
      m_r[k][1] <= MinW'(pr_r[k][2]) - MinW'(pr_r[k][3]);
      m_r[k][2] <= MinW'(pr_r[k][4]) - MinW'(pr_r[k][5]);
    end
    p2_r <= p_r;
    // det/n0 use minor (1,2); n1 uses (3,2); n2 uses (1,3)
    for (int d = 0; d < 4; d++) begin
      for (int j = 0; j < 3; j++) begin
        t_r[d][j] <= DetW'(p2_r[d][j] * m_r[(d < 2) ? 0 : d - 1][j]);
      end
    end
    for (int d = 0; d < 4; d++) det_r[d] <= t_r[d][0] - t_r[d][1] + t_r[d][2];
  end

  always_comb begin
    for (int d = 0; d < 4; d++) out_det[d] = det_r[d];
  end
  assign out_vld = v4_r;

endmodule

// ===== rtl/core/lsc_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, 32+1 bits.
// Quotients at or above 2^33 are caught up front by a compare, so only the low
// bits need stages.
module lsc_div #(
  parameter int FracBits = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic                          in_neg,
  input  logic                          in_ovf,
  input  logic [lsc_pkg::MagW+FracBits-1:0] in_num,
  input  logic [lsc_pkg::MagW-1:0]      in_den,
  output logic                          out_vld,
  output logic [lsc_pkg::OutW-1:0]      out_q
);
  import lsc_pkg::*;

  localparam int QB = OutW + 1;
  localparam int NW = MagW + FracBits;
  localparam int RW = MagW + 1;

  logic          v_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];
  logic [NW-1:0] n_r   [QB+1];
  logic [MagW-1:0] d_r [QB+1];
  logic [RW-1:0] rem_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];

  always_comb begin
    v_r[0] = in_vld; neg_r[0] = in_neg; ovf_r[0] = in_ovf;
    n_r[0] = in_num; d_r[0] = in_den;
    // remainder preloaded with the numerator bits above the quotient window
    rem_r[0] = RW'(in_num >> QB);
    q_r[0] = '0;
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RW:0] sh;
    logic [RW:0] df;
    assign sh = {rem_r[s], n_r[s][QB-1-s]};
    assign df = sh - {2'b00, d_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s+1] <= 1'b0;
      else        v_r[s+1] <= v_r[s];
    end
    always_ff @(posedge clk) begin
      neg_r[s+1] <= neg_r[s]; ovf_r[s+1] <= ovf_r[s];
      n_r[s+1] <= n_r[s]; d_r[s+1] <= d_r[s];
      if (!df[RW]) begin
        rem_r[s+1] <= df[RW-1:0];
        q_r[s+1] <= q_r[s] | (QB'(1) << (QB-1-s));
      end else begin
        rem_r[s+1] <= sh[RW-1:0];
        q_r[s+1] <= q_r[s];
      end
    end
  end

  logic [QB-1:0] lim;
  logic [QB-1:0] v;
  always_comb begin
    lim = ovf_r[QB] ? '0 : '0;
    lim = neg_r[QB] ? QB'(33'h0_8000_0000) : QB'(33'h0_7FFF_FFFF);
    v = (ovf_r[QB] || q_r[QB] > lim) ? lim : q_r[QB];
    out_q = OutW'(neg_r[QB] ? QB'(0) - v : v);
  end
  assign out_vld = v_r[QB];

endmodule

// ===== rtl/core/linear_solve_3x3_cramer.sv =====
`timescale 1ns / 1ps
// Channel | Ports                         | Handshake
// input   | start, busy, in_word          | taken when start && !busy
// result  | out_strobe, out_word          | one strobe per word, no stall
// config  | cfg_we, cfg_wdata             | written when cfg_we
//
// One word enters per cycle; busy is held low. Each word passes four
// determinant stages, one sign/threshold stage, one quotient bit per
// divider stage and a final output register. Reset clears all valid bits and
// loads the threshold with 1. The receiver cannot stall, so nothing backs up.
module linear_solve_3x3_cramer #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lsc_pkg::lsc_in_t          in_word,
  output logic                      out_strobe,
  output lsc_pkg::lsc_out_t         out_word,
  input  logic                      cfg_we,
  input  logic [lsc_pkg::ThrW-1:0]  cfg_wdata
);
  import lsc_pkg::*;

  localparam int QB = OutW + 1;
  localparam int NW = MagW + FRAC_BITS;
  localparam int Lat = QB;

  logic [ThrW-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      thr_r <= ThrW'(1);
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  assign busy = 1'b0;

  logic                   dv;
  logic signed [DetW-1:0] det [4];
  lsc_det u_det (.clk(clk), .rst_n(rst_n), .in_vld(start), .in_word(in_word),
                 .out_vld(dv), .out_det(det));

  // sign/magnitude stage; singular decision and overflow screen
  logic                   sv_r, sing_r;
  logic [MagW-1:0]        dm_r;
  logic                   neg_r [3];
  logic                   ovf_r [3];
  logic [NW-1:0]          nm_r  [3];
  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= 1'b0;
    else        sv_r <= dv;
  end
  always_ff @(posedge clk) begin
    logic [MagW-1:0] dm;
    logic [MagW-1:0] nm;
    dm = MagW'(det[0][DetW-1] ? -det[0] : det[0]);
    dm_r   <= dm;
    sing_r <= (dm == '0) || ({1'b0, dm} < (DetW)'(thr_r));
    for (int k = 0; k < 3; k++) begin
      nm = MagW'(det[k+1][DetW-1] ? -det[k+1] : det[k+1]);
      neg_r[k] <= det[k+1][DetW-1] ^ det[0][DetW-1];
      nm_r[k]  <= NW'(nm) << FRAC_BITS;
      // quotient >= 2^QB when top numerator bits already reach the divisor
      ovf_r[k] <= ((NW'(nm) << FRAC_BITS) >> QB) >= NW'(dm);
    end
  end

  logic [OutW-1:0] q [3];
  logic            qv [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    lsc_div #(.FracBits(FRAC_BITS)) u_div (
      .clk(clk), .rst_n(rst_n), .in_vld(sv_r), .in_neg(neg_r[k]),
      .in_ovf(ovf_r[k]), .in_num(nm_r[k]), .in_den(dm_r | MagW'(sing_r)),
      .out_vld(qv[k]), .out_q(q[k]));
  end

  // singular flag rides alongside the divider
  logic sg_r [Lat];
  always_ff @(posedge clk) begin
    sg_r[0] <= sing_r;
    for (int i = 1; i < Lat; i++) sg_r[i] <= sg_r[i-1];
  end

  // output register: drop quotients when singular
  logic     strobe_r;
  lsc_out_t word_r;
  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= qv[0] & qv[1] & qv[2];
  end
  always_ff @(posedge clk) begin
    word_r.solution_first  <= sg_r[Lat-1] ? '0 : q[0];
    word_r.solution_second <= sg_r[Lat-1] ? '0 : q[1];
    word_r.solution_third  <= sg_r[Lat-1] ? '0 : q[2];
    word_r.singular        <= sg_r[Lat-1];
  end
  assign out_strobe = strobe_r;
  assign out_word   = word_r;

endmodule
